// ----- src/srs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_pkg
// Shared widths, constants and the divider beat type of the snow/rain splitter.
// ----------------------------------------------------------------------------
package srs_pkg;

    // field widths
    localparam int PRECIP_W = 16;
    localparam int TEMP_W   = 14;
    localparam int ELEV_W   = 14;
    localparam int FACTOR_W = 16;
    localparam int OUT_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // solid fraction, Q0.16 held in 17 bits so that 1.0 is exact
    localparam int FS_W = 17;
    localparam logic [FS_W-1:0] FS_ONE  = 17'h10000;
    localparam logic [FS_W-1:0] FS_ZERO = 17'h00000;

    // mean-temperature ramp, centidegrees
    localparam logic signed [TEMP_W-1:0] T_COLD = -14'sd100;
    localparam logic signed [TEMP_W-1:0] T_WARM = 14'sd300;
    localparam int T_SPAN = 400;

    // divider: quotient = floor(num * 2^16 / den) with num < den
    localparam int DIV_W      = TEMP_W + 1;
    localparam int QUO_W      = 16;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    // scaling products
    localparam int PROD1_W     = PRECIP_W + FS_W;
    localparam int PROD2_W     = PROD1_W + FACTOR_W;
    localparam int SCALE_SHIFT = 30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEVATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAIN_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SNOW_FACTOR = 2'd2;

    localparam logic [ELEV_W-1:0]   ELEV_RST   = 14'd0;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd16384;

    localparam int ELEV_SPLIT_M_DEFAULT = 1500;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } srs_div_t;

endpackage
`default_nettype wire

// ----- src/snow_rain_splitter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: prep, 4 divider slices and two multiply stages from input beat to
//   result beat; the slice count is set by the 16 quotient bits at 4 bits per slice.
// Throughput: one beat per cycle; a stall at the output freezes the whole pipe.
// Reset: rst_n clears all valid bits and loads elevation 0 and both factors 1.0.
// ----------------------------------------------------------------------------
// snow_rain_splitter_core
// Splits a precipitation sample into corrected rain and snow.
// ----------------------------------------------------------------------------
module snow_rain_splitter_core #(
    parameter int ELEV_SPLIT_M = srs_pkg::ELEV_SPLIT_M_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [srs_pkg::PRECIP_W-1:0]   precip,
    input  wire logic signed [srs_pkg::TEMP_W-1:0] temp_mean,
    input  wire logic signed [srs_pkg::TEMP_W-1:0] temp_low,
    input  wire logic signed [srs_pkg::TEMP_W-1:0] temp_high,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [srs_pkg::OUT_W-1:0]           rain,
    output logic [srs_pkg::OUT_W-1:0]           snow,
    output logic                                bounds_swapped
);
    import srs_pkg::*;

    // sideband that rides alongside the divider
    typedef struct packed {
        logic [PRECIP_W-1:0] precip;
        logic                use_div;   // fraction comes from the quotient
        logic [FS_W-1:0]     fs_fix;    // fraction when clamped to 0 or 1
        logic                swapped;
    } side_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ELEV_W-1:0]   elevation_reg;
    logic [FACTOR_W-1:0] rain_factor_reg;
    logic [FACTOR_W-1:0] snow_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elevation_reg   <= ELEV_RST;
            rain_factor_reg <= FACTOR_RST;
            snow_factor_reg <= FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ELEVATION:   elevation_reg   <= cfg_data[ELEV_W-1:0];
                REG_RAIN_FACTOR: rain_factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_SNOW_FACTOR: snow_factor_reg <= cfg_data[FACTOR_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together unless the result
    // register holds a beat that is not taken
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // ------------------------------------------------------------------
    // stage 0: method select, clamps, divider operands
    // ------------------------------------------------------------------
    srs_div_t div_s0_next;
    side_t    side_s0_next;
    srs_div_t div_s0_reg;
    logic     valid_s0_reg;

    logic signed [DIV_W-1:0] t_ext;
    logic signed [DIV_W-1:0] lo_ext;
    logic signed [DIV_W-1:0] hi_ext;
    logic signed [DIV_W-1:0] hi_clamped;
    logic                    mean_method;

    assign t_ext       = DIV_W'(temp_mean);
    assign lo_ext      = DIV_W'(temp_low);
    assign hi_ext      = DIV_W'(temp_high);
    assign mean_method = (elevation_reg >= ELEV_W'(ELEV_SPLIT_M));
    // max below min is pulled up to min
    assign hi_clamped  = (hi_ext < lo_ext) ? lo_ext : hi_ext;

    always_comb
    begin
        div_s0_next.rem      = '0;
        div_s0_next.den      = DIV_W'(1);
        div_s0_next.quo      = '0;
        side_s0_next.precip  = precip;
        side_s0_next.use_div = 1'b0;
        side_s0_next.fs_fix  = FS_ZERO;
        side_s0_next.swapped = 1'b0;
        if (mean_method)
        begin
            if (temp_mean <= T_COLD)
            begin
                side_s0_next.fs_fix = FS_ONE;
            end
            else if (temp_mean >= T_WARM)
            begin
                side_s0_next.fs_fix = FS_ZERO;
            end
            else
            begin
                side_s0_next.use_div = 1'b1;
                div_s0_next.rem      = DIV_W'(DIV_W'(T_WARM) - t_ext);
                div_s0_next.den      = DIV_W'(T_SPAN);
            end
        end
        else
        begin
            side_s0_next.swapped = (hi_ext < lo_ext);
            if (hi_clamped <= 0)
            begin
                side_s0_next.fs_fix = FS_ONE;
            end
            else if (lo_ext >= 0)
            begin
                side_s0_next.fs_fix = FS_ZERO;
            end
            else
            begin
                // lo < 0 < hi, so -lo < hi - lo and the quotient fits 16 bits
                side_s0_next.use_div = 1'b1;
                div_s0_next.rem      = DIV_W'(-lo_ext);
                div_s0_next.den      = DIV_W'(hi_clamped - lo_ext);
            end
        end
    end

    side_t side_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_s0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_s0_reg  <= div_s0_next;
            side_reg[0] <= side_s0_next;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // divider slices
    // ------------------------------------------------------------------
    srs_div_t div_pipe   [DIV_STAGES+1];
    logic     valid_pipe [DIV_STAGES+1];

    assign div_pipe[0]   = div_s0_reg;
    assign valid_pipe[0] = valid_s0_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        srs_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_pipe[g]),
            .in_div    (div_pipe[g]),
            .out_valid (valid_pipe[g+1]),
            .out_div   (div_pipe[g+1])
        );
    end

    // ------------------------------------------------------------------
    // multiply stage 1: precip times liquid and solid shares
    // ------------------------------------------------------------------
    logic [FS_W-1:0]    fs_final;
    logic [FS_W-1:0]    rain_share;
    logic [PROD1_W-1:0] rain_p_reg;
    logic [PROD1_W-1:0] snow_p_reg;
    logic               swapped_m1_reg;
    logic               valid_m1_reg;

    assign fs_final   = side_reg[DIV_STAGES].use_div
                      ? {1'b0, div_pipe[DIV_STAGES].quo}
                      : side_reg[DIV_STAGES].fs_fix;
    assign rain_share = FS_ONE - fs_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_m1_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_m1_reg <= valid_pipe[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rain_p_reg     <= PROD1_W'(side_reg[DIV_STAGES].precip) * PROD1_W'(rain_share);
            snow_p_reg     <= PROD1_W'(side_reg[DIV_STAGES].precip) * PROD1_W'(fs_final);
            swapped_m1_reg <= side_reg[DIV_STAGES].swapped;
        end
    end

    // ------------------------------------------------------------------
    // multiply stage 2: correction factors, drop 30 fraction bits
    // ------------------------------------------------------------------
    logic [PROD2_W-1:0] rain_full;
    logic [PROD2_W-1:0] snow_full;
    logic [OUT_W-1:0]   rain_reg;
    logic [OUT_W-1:0]   snow_reg;
    logic               swapped_reg;

    assign rain_full = PROD2_W'(rain_p_reg) * PROD2_W'(rain_factor_reg);
    assign snow_full = PROD2_W'(snow_p_reg) * PROD2_W'(snow_factor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid_m1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rain_reg    <= rain_full[SCALE_SHIFT+OUT_W-1:SCALE_SHIFT];
            snow_reg    <= snow_full[SCALE_SHIFT+OUT_W-1:SCALE_SHIFT];
            swapped_reg <= swapped_m1_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign rain           = rain_reg;
    assign snow           = snow_reg;
    assign bounds_swapped = swapped_reg;

endmodule
`default_nettype wire

// ----- src/srs_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_div_stage
// One registered slice of the fraction divider: DIV_STEPS restoring steps.
// ----------------------------------------------------------------------------
module srs_div_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             in_valid,
    input  wire srs_pkg::srs_div_t in_div,
    output logic                  out_valid,
    output srs_pkg::srs_div_t     out_div
);
    import srs_pkg::*;

    srs_div_t div_next;
    srs_div_t div_reg;
    logic     valid_reg;

    always_comb
    begin
        logic [DIV_W-1:0] r;
        logic [DIV_W:0]   r2;
        logic [QUO_W-1:0] q;
        r = in_div.rem;
        q = in_div.quo;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, in_div.den})
            begin
                r2 = r2 - {1'b0, in_div.den};
                q  = {q[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q  = {q[QUO_W-2:0], 1'b0};
            end
            r = r2[DIV_W-1:0];
        end
        div_next.rem = r;
        div_next.den = in_div.den;
        div_next.quo = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule
`default_nettype wire

// ----- src/srs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks on the snow/rain splitter, bound to the top level.
// ----------------------------------------------------------------------------
module srs_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [srs_pkg::PRECIP_W-1:0]   precip,
    input  wire logic signed [srs_pkg::TEMP_W-1:0] temp_mean,
    input  wire logic signed [srs_pkg::TEMP_W-1:0] temp_low,
    input  wire logic signed [srs_pkg::TEMP_W-1:0] temp_high,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [srs_pkg::OUT_W-1:0]      rain,
    input  wire logic [srs_pkg::OUT_W-1:0]      snow,
    input  wire logic                           bounds_swapped
);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(precip) && $stable(temp_mean)
                                  && $stable(temp_low) && $stable(temp_high))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rain) && $stable(snow)
                                    && $stable(bounds_swapped))
        else $error("result beat changed while stalled");

    // with no result pending the pipe must take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // clamped bounds give an all-rain or all-snow split
    a_swap_pure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bounds_swapped |-> (rain == '0) || (snow == '0))
        else $error("swapped bounds with mixed split");

    // a stall only comes from a held result beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind snow_rain_splitter_core srs_checker u_srs_checker (.*);
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives precipitation samples into snow_rain_splitter_core under random
// valid/ready pacing. Each accepted sample is predicted in the bench and
// checked field by field against the result beats. The run starts with a
// short table of corner samples, then random traffic over several register
// settings. One phase holds the result side off long enough to back up the
// pipe, and one phase runs both sides with no idle cycles.
// ----------------------------------------------------------------------------
module testbench;
    import srs_pkg::*;

    localparam int SPLIT_ELEV  = ELEV_SPLIT_M_DEFAULT;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 150;   // long result-side hold-off
    localparam int QUIET_LIMIT = 2000;  // cycles with no beat before giving up
    localparam int ROWS        = 21;
    // index past the end of the register map, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] rain;
        logic [OUT_W-1:0] snow;
        logic             swapped;
    } split_t;

    // one corner sample; typed rows carry their result, the rest use the predictor
    typedef struct packed {
        int                        elev;
        logic [PRECIP_W-1:0]       p;
        logic signed [TEMP_W-1:0]  tm;
        logic signed [TEMP_W-1:0]  tl;
        logic signed [TEMP_W-1:0]  th;
        bit                        typed;
        split_t                    want;
    } row_t;

    localparam split_t NONE = '0;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [PRECIP_W-1:0]          precip = '0;
    logic signed [TEMP_W-1:0]     temp_mean = '0;
    logic signed [TEMP_W-1:0]     temp_low = '0;
    logic signed [TEMP_W-1:0]     temp_high = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [OUT_W-1:0]             rain;
    logic [OUT_W-1:0]             snow;
    logic                         bounds_swapped;

    // bench copy of the register file
    logic [ELEV_W-1:0]            elev_q = ELEV_RST;
    logic [FACTOR_W-1:0]          rain_fac_q = FACTOR_RST;
    logic [FACTOR_W-1:0]          snow_fac_q = FACTOR_RST;

    split_t                       split_q[$];   // results still owed by the block
    bit                           in_fire = 1'b0;
    bit                           out_fire = 1'b0;
    bit                           no_idle = 1'b0;
    bit                           hold_req = 1'b0;
    bit                           row_typed = 1'b0;
    split_t                       row_want = '0;
    int                           fails = 0;
    int                           quiet = 0;

    row_t corner_rows [ROWS] = '{
        // min/max method at reset factors (1.0): shares come out as whole precip
        '{0,     16'd0,     0,     -500,  500,   1'b1, '{18'd0,     18'd0,     1'b0}},
        '{0,     16'd65535, 0,     -8192, -1,    1'b1, '{18'd0,     18'd65535, 1'b0}},
        '{0,     16'd65535, 0,     0,     8191,  1'b1, '{18'd65535, 18'd0,     1'b0}},
        '{0,     16'd1000,  0,     500,   -200,  1'b1, '{18'd1000,  18'd0,     1'b1}},
        '{0,     16'd1000,  0,     -200,  -500,  1'b1, '{18'd0,     18'd1000,  1'b1}},
        '{0,     16'd1000,  0,     0,     0,     1'b1, '{18'd0,     18'd1000,  1'b0}},
        '{0,     16'h5555,  8191,  8191,  -8192, 1'b1, '{18'h5555,  18'd0,     1'b1}},
        '{0,     16'd40000, 0,     -100,  300,   1'b0, NONE},
        '{0,     16'd12345, 0,     -8192, 8191,  1'b0, NONE},
        '{0,     16'd65535, 0,     -1,    1,     1'b0, NONE},
        '{0,     16'd65535, 0,     -8192, 1,     1'b0, NONE},
        '{0,     16'hAAAA,  -8192, -1,    8191,  1'b0, NONE},
        '{1499,  16'd777,   8191,  -300,  100,   1'b0, NONE},
        // mean method: low/high ignored, never flagged even with high below low
        '{1500,  16'd20000, -100,  500,   -500,  1'b1, '{18'd0,     18'd20000, 1'b0}},
        '{1500,  16'd20000, 300,   500,   -500,  1'b1, '{18'd20000, 18'd0,     1'b0}},
        '{1500,  16'd20000, -8192, 0,     0,     1'b1, '{18'd0,     18'd20000, 1'b0}},
        '{1500,  16'd20000, 8191,  0,     0,     1'b1, '{18'd20000, 18'd0,     1'b0}},
        '{1500,  16'd20000, 100,   -8192, 8191,  1'b1, '{18'd10000, 18'd10000, 1'b0}},
        '{1500,  16'd65535, -99,   0,     0,     1'b0, NONE},
        '{1500,  16'd65535, 299,   0,     0,     1'b0, NONE},
        '{16383, 16'd65535, 0,     8191,  -8192, 1'b0, NONE}
    };

    snow_rain_splitter_core #(
        .ELEV_SPLIT_M   (SPLIT_ELEV)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .precip         (precip),
        .temp_mean      (temp_mean),
        .temp_low       (temp_low),
        .temp_high      (temp_high),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rain           (rain),
        .snow           (snow),
        .bounds_swapped (bounds_swapped)
    );

    always #5 clk = ~clk;

    // Rain/snow split of one sample under the current register copy.
    function automatic split_t split_sample(input logic [PRECIP_W-1:0] p,
                                            input logic signed [TEMP_W-1:0] tm,
                                            input logic signed [TEMP_W-1:0] tl,
                                            input logic signed [TEMP_W-1:0] th);
        longint lo;
        longint hi;
        longint solid;
        split_t r;
        r = '0;
        if (elev_q >= SPLIT_ELEV)
        begin
            // ramp on mean temperature, full snow at the cold end
            if (tm <= T_COLD)
                solid = longint'(FS_ONE);
            else if (tm >= T_WARM)
                solid = 0;
            else
                solid = (longint'(T_WARM) - longint'(tm)) * 65536 / T_SPAN;
        end
        else
        begin
            lo = tl;
            hi = th;
            if (hi < lo)
            begin
                hi = lo;
                r.swapped = 1'b1;
            end
            if (hi <= 0)
                solid = longint'(FS_ONE);
            else if (lo >= 0)
                solid = 0;
            else
                solid = (-lo * 65536) / (hi - lo);
        end
        r.rain = OUT_W'((longint'(p) * (longint'(FS_ONE) - solid)
                         * longint'(rain_fac_q)) >> SCALE_SHIFT);
        r.snow = OUT_W'((longint'(p) * solid * longint'(snow_fac_q)) >> SCALE_SHIFT);
        return r;
    endfunction

    // Everything is stable at the falling edge, so beats are taken here and
    // the result does not hinge on event order at the rising edge.
    always @(negedge clk)
    begin
        split_t got;
        split_t want;
        in_fire  = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (out_fire)
        begin
            got = '{rain, snow, bounds_swapped};
            if (split_q.size() == 0)
            begin
                $error("result beat with nothing owed: rain=%0d snow=%0d swapped=%0b",
                       got.rain, got.snow, got.swapped);
                fails++;
            end
            else
            begin
                want = split_q.pop_front();
                if (got.rain !== want.rain)
                begin
                    $error("rain: expected %0d, got %0d", want.rain, got.rain);
                    fails++;
                end
                if (got.snow !== want.snow)
                begin
                    $error("snow: expected %0d, got %0d", want.snow, got.snow);
                    fails++;
                end
                if (got.swapped !== want.swapped)
                begin
                    $error("bounds_swapped: expected %0b, got %0b", want.swapped,
                           got.swapped);
                    fails++;
                end
            end
        end
        if (in_fire)
            split_q.push_back(row_typed ? row_want
                              : split_sample(precip, temp_mean, temp_low, temp_high));
    end

    // Watchdog: a long run of cycles with no beat on either side means a hang.
    always @(posedge clk)
    begin
        if (in_fire || out_fire)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_sample(input logic [PRECIP_W-1:0] p,
                               input logic signed [TEMP_W-1:0] tm,
                               input logic signed [TEMP_W-1:0] tl,
                               input logic signed [TEMP_W-1:0] th);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        precip    <= p;
        temp_mean <= tm;
        temp_low  <= tl;
        temp_high <= th;
        @(posedge clk);
        while (!in_fire) @(posedge clk);
    endtask

    // Stop offering samples and wait until every owed result has come back.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (split_q.size() != 0) @(posedge clk);
    endtask

    // Only called with the pipe drained. Mirrors the write into the bench copy.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_ELEVATION:   elev_q = data[ELEV_W-1:0];
            REG_RAIN_FACTOR: rain_fac_q = data;
            REG_SNOW_FACTOR: snow_fac_q = data;
            default: ;
        endcase
    endtask

    // Mostly near the ramp and freezing point, sometimes anywhere in 14 bits.
    function automatic logic signed [TEMP_W-1:0] rand_temp();
        case ($urandom_range(0, 3))
            0: return TEMP_W'($urandom);
            1: return TEMP_W'(int'($urandom_range(0, 16000)) - 8000);
            default: return TEMP_W'(int'($urandom_range(0, 1000)) - 400);
        endcase
    endfunction

    task automatic send_random();
        logic [PRECIP_W-1:0]      p;
        logic signed [TEMP_W-1:0] tl;
        logic signed [TEMP_W-1:0] th;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            default: p = PRECIP_W'($urandom);
        endcase
        if (elev_q < SPLIT_ELEV && $urandom_range(0, 9) < 7)
        begin
            // straddling zero is the divider path
            if ($urandom_range(0, 1) != 0)
            begin
                tl = TEMP_W'(-int'($urandom_range(1, 500)));
                th = TEMP_W'($urandom_range(1, 500));
            end
            else
            begin
                tl = TEMP_W'(-int'($urandom_range(1, 8192)));
                th = TEMP_W'($urandom_range(1, 8191));
            end
        end
        else
        begin
            tl = rand_temp();
            th = rand_temp();
        end
        send_sample(p, rand_temp(), tl, th);
    endtask

    // Drain, load all three registers, then stream random samples.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] elev_data,
                             input logic [CFG_DATA_W-1:0] rain_fac,
                             input logic [CFG_DATA_W-1:0] snow_fac,
                             input int n);
        drain_pipe();
        cfg_write(REG_ELEVATION, elev_data);
        cfg_write(REG_RAIN_FACTOR, rain_fac);
        cfg_write(REG_SNOW_FACTOR, snow_fac);
        if ($urandom_range(0, 1) != 0)
            cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        for (int i = 0; i < n; i++)
            send_random();
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_elev();
        if ($urandom_range(0, 1) != 0)
            return CFG_DATA_W'($urandom);
        return CFG_DATA_W'(SPLIT_ELEV - 2 + int'($urandom_range(0, 4)));
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner table, first rows rely on the reset register values
        for (int i = 0; i < ROWS; i++)
        begin
            if (corner_rows[i].elev != int'(elev_q))
            begin
                drain_pipe();
                cfg_write(REG_ELEVATION, CFG_DATA_W'(corner_rows[i].elev));
                cfg_we <= 1'b0;
            end
            row_typed = corner_rows[i].typed;
            row_want  = corner_rows[i].want;
            send_sample(corner_rows[i].p, corner_rows[i].tm, corner_rows[i].tl,
                        corner_rows[i].th);
        end
        row_typed = 1'b0;

        run_phase(16'd1499, 16'd0, 16'hFFFF, 60);
        run_phase(16'd1500, 16'hFFFF, 16'd0, 60);
        // back-pressure: hold results off while samples keep coming
        drain_pipe();
        hold_req = 1'b1;
        run_phase(16'd9000, 16'hFFFF, 16'hFFFF, 60);
        // full-rate stretch, no idle on either side
        no_idle = 1'b1;
        run_phase(16'd0, 16'hFFFF, 16'hFFFF, 60);
        no_idle = 1'b0;
        run_phase(rand_elev(), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 60);
        run_phase(rand_elev(), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 60);
        run_phase(16'd16383, 16'd16384, 16'd16384, 60);
        run_phase(rand_elev(), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 60);
        // upper data bits beyond the elevation width are dropped
        run_phase(16'hC000, 16'd8192, 16'd24576, 60);

        drain_pipe();
        repeat (12) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
